// ===== design/srpc_pkg.sv =====
`default_nettype none
package srpc_pkg;

  // SLIP framing codes
  localparam logic [7:0] CODE_END     = 8'hC0;
  localparam logic [7:0] CODE_ESC     = 8'hDB;
  localparam logic [7:0] CODE_ESC_END = 8'hDC;
  localparam logic [7:0] CODE_ESC_ESC = 8'hDD;

  localparam logic [7:0] CMD_ACK = 8'd6;
  localparam int unsigned HDR_BYTES = 6;

  // header byte positions
  localparam int unsigned HDR_DEVICE  = 0;
  localparam int unsigned HDR_COMMAND = 1;
  localparam int unsigned HDR_LEN_LO  = 2;
  localparam int unsigned HDR_LEN_HI  = 3;
  localparam int unsigned HDR_SUM     = 4;
  localparam int unsigned HDR_FIELDS  = 5;

  // status codes
  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_SHORT  = 3'd1;
  localparam logic [2:0] ST_LENGTH = 3'd2;
  localparam logic [2:0] ST_SUM    = 3'd3;
  localparam logic [2:0] ST_DEVICE = 3'd4;
  localparam logic [2:0] ST_NOACK  = 3'd5;

  // configuration register indexes
  localparam logic REG_EXPECTED_DEVICE = 1'b0;
  localparam logic REG_REPLY_CAPACITY  = 1'b1;

  // decoded token from the front end: one data byte or a frame close
  typedef struct packed {
    logic       is_close;
    logic [7:0] data;
  } token_t;

  // one result item
  typedef struct packed {
    logic        is_payload;
    logic [7:0]  payload_byte;
    logic [15:0] payload_index;
    logic        is_final;
    logic [2:0]  status;
    logic [7:0]  reply_fields;
  } result_t;

endpackage
`default_nettype wire

// ===== design/slip_reply_packet_checker_top.sv =====
`default_nettype none
// SLIP reply packet checker.
// Input channel: one raw serial byte per transfer on rx_byte (in_valid/in_stall).
// The front end strips SLIP framing (END, ESC sequences) and queues decoded
// bytes and frame-close marks; the back end captures the six-byte reply header,
// keeps the end-around-carry checksum and emits results on the output channel
// (out_valid/out_stall). A result is either one payload byte with its buffer
// index, or, at the closing END, one final status with the header fields byte.
// Throughput: one input byte per cycle while the queue has room; the back end
// retires one queued token per cycle while the output register is not held.
// A result passes from the token queue into the output result register before
// it shows on the output ports.
// Stalls: the output register holds while out_stall is high; the queue of
// QUEUE_DEPTH tokens keeps absorbing input until full, then in_stall rises.
// Header bytes and dropped payload bytes yield no result but still pass
// through the queue; bare framing bytes stop in the front end.
// Reset (rst, synchronous): waits for an opening END, queue and output empty;
// expected_device and reply_capacity return to zero.
// Registers (APB, pready always high): 0x0 expected_device, 0x4 reply_capacity.
module slip_reply_packet_checker_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // raw byte input
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  // result output
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             is_payload,
  output logic [7:0]       payload_byte,
  output logic [15:0]      payload_index,
  output logic             is_final,
  output logic [2:0]       status,
  output logic [7:0]       reply_fields,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  logic [7:0]        expected_device;
  logic [15:0]       reply_capacity;
  logic              cfg_write;
  logic              reg_sel;
  logic              in_accept;
  logic              push;
  srpc_pkg::token_t  push_token;
  logic              queue_full;
  logic              pop;
  logic              head_valid;
  srpc_pkg::token_t  head_token;
  srpc_pkg::result_t result;

  // configuration registers; the low address bits are not decoded
  assign pready    = 1'b1;
  assign reg_sel   = paddr[2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_device <= '0;
      reply_capacity  <= '0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        srpc_pkg::REG_EXPECTED_DEVICE: expected_device <= pwdata[7:0];
        srpc_pkg::REG_REPLY_CAPACITY:  reply_capacity  <= pwdata[15:0];
        default:                       ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      srpc_pkg::REG_EXPECTED_DEVICE: prdata = {24'd0, expected_device};
      srpc_pkg::REG_REPLY_CAPACITY:  prdata = {16'd0, reply_capacity};
      default:                       prdata = '0;
    endcase
  end

  // take a byte whenever the queue has room
  assign in_stall  = queue_full;
  assign in_accept = in_valid && !in_stall;

  srpc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_accept),
    .rx_byte    (rx_byte),
    .push       (push),
    .push_token (push_token)
  );

  srpc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_token (push_token),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_token (head_token)
  );

  srpc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .expected_device (expected_device),
    .reply_capacity  (reply_capacity),
    .head_valid      (head_valid),
    .head_token      (head_token),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .result          (result)
  );

  // break the result register out onto the field ports
  assign is_payload    = result.is_payload;
  assign payload_byte  = result.payload_byte;
  assign payload_index = result.payload_index;
  assign is_final      = result.is_final;
  assign status        = result.status;
  assign reply_fields  = result.reply_fields;

endmodule
`default_nettype wire

// ===== design/srpc_front.sv =====
`default_nettype none
module srpc_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            accept,
  input  wire logic [7:0]      rx_byte,
  output logic                 push,
  output srpc_pkg::token_t     push_token
);

  logic in_frame;
  logic escape_pending;
  logic got_data;
  logic in_frame_next;
  logic escape_pending_next;
  logic got_data_next;

  always_comb begin
    in_frame_next       = in_frame;
    escape_pending_next = escape_pending;
    got_data_next       = got_data;
    push                = 1'b0;
    push_token.is_close = 1'b0;
    push_token.data     = rx_byte;
    if (accept) begin
      priority if (!in_frame) begin
        if (rx_byte == srpc_pkg::CODE_END) begin
          in_frame_next       = 1'b1;
          escape_pending_next = 1'b0;
          got_data_next       = 1'b0;
        end
      end else if (rx_byte == srpc_pkg::CODE_END) begin
        // drop any pending escape; an empty frame stays open
        escape_pending_next = 1'b0;
        if (got_data) begin
          push                = 1'b1;
          push_token.is_close = 1'b1;
          in_frame_next       = 1'b0;
          got_data_next       = 1'b0;
        end
      end else if (escape_pending) begin
        escape_pending_next = 1'b0;
        push                = 1'b1;
        got_data_next       = 1'b1;
        priority if (rx_byte == srpc_pkg::CODE_ESC_END) begin
          push_token.data = srpc_pkg::CODE_END;
        end else if (rx_byte == srpc_pkg::CODE_ESC_ESC) begin
          push_token.data = srpc_pkg::CODE_ESC;
        end else begin
          push_token.data = rx_byte;
        end
      end else if (rx_byte == srpc_pkg::CODE_ESC) begin
        escape_pending_next = 1'b1;
      end else begin
        push          = 1'b1;
        got_data_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame       <= 1'b0;
      escape_pending <= 1'b0;
      got_data       <= 1'b0;
    end else begin
      in_frame       <= in_frame_next;
      escape_pending <= escape_pending_next;
      got_data       <= got_data_next;
    end
  end

endmodule
`default_nettype wire

// ===== design/srpc_queue.sv =====
`default_nettype none
module srpc_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire srpc_pkg::token_t push_token,
  output logic                  full,
  input  wire logic             pop,
  output logic                  head_valid,
  output srpc_pkg::token_t      head_token
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  srpc_pkg::token_t entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full       = (count == CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_token = entries[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_token;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== design/srpc_back.sv =====
`default_nettype none
module srpc_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [7:0]       expected_device,
  input  wire logic [15:0]      reply_capacity,
  input  wire logic             head_valid,
  input  wire srpc_pkg::token_t head_token,
  output logic                  pop,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output srpc_pkg::result_t     result
);

  logic [16:0] byte_count;
  logic [8:0]  running_sum;
  logic [7:0]  header_store [srpc_pkg::HDR_BYTES];

  logic [16:0]       byte_count_next;
  logic [8:0]        running_sum_next;
  logic              emit;
  srpc_pkg::result_t result_next;
  logic              is_short;
  logic [16:0]       payload_pos;
  logic [16:0]       hdr_len;
  logic [2:0]        frame_status;
  logic [7:0]        sum_operand;
  logic [9:0]        sum_raw;
  logic [8:0]        sum_folded;
  logic [2:0]        hdr_slot;

  function automatic logic [2:0] pick_status(
    input logic        short_frame,
    input logic [16:0] count,
    input logic [16:0] len,
    input logic [7:0]  sum_byte,
    input logic [7:0]  sum_field,
    input logic [7:0]  device,
    input logic [7:0]  want_device,
    input logic [7:0]  command
  );
    logic [2:0] st;
    priority if (short_frame)        st = srpc_pkg::ST_SHORT;
    else if (count != len)           st = srpc_pkg::ST_LENGTH;
    else if (sum_field != sum_byte)  st = srpc_pkg::ST_SUM;
    else if (device != want_device)  st = srpc_pkg::ST_DEVICE;
    else if (command != srpc_pkg::CMD_ACK) st = srpc_pkg::ST_NOACK;
    else                             st = srpc_pkg::ST_OK;
    return st;
  endfunction

  assign pop         = head_valid && (!out_valid || !out_stall);
  assign is_short    = (byte_count < 17'(srpc_pkg::HDR_BYTES));
  assign payload_pos = byte_count - 17'(srpc_pkg::HDR_BYTES);
  assign hdr_len     = {1'b0, header_store[srpc_pkg::HDR_LEN_HI],
                        header_store[srpc_pkg::HDR_LEN_LO]};
  assign hdr_slot    = byte_count[2:0];
  assign frame_status = pick_status(is_short, byte_count, hdr_len, running_sum[7:0],
                                    header_store[srpc_pkg::HDR_SUM],
                                    header_store[srpc_pkg::HDR_DEVICE], expected_device,
                                    header_store[srpc_pkg::HDR_COMMAND]);

  // the checksum byte itself counts as zero in the sum
  assign sum_operand = (is_short && hdr_slot == 3'(srpc_pkg::HDR_SUM)) ? 8'd0
                                                                      : head_token.data;
  // end-around carry: fold the carry out of bit 7 back in
  assign sum_raw    = {1'b0, running_sum} + {2'b00, sum_operand};
  assign sum_folded = 9'({2'b00, sum_raw[9:8]} + {2'b00, sum_raw[7:0]});

  always_comb begin
    byte_count_next  = byte_count;
    running_sum_next = running_sum;
    emit             = 1'b0;
    result_next      = '0;
    if (head_token.is_close) begin
      emit                     = 1'b1;
      result_next.is_final     = 1'b1;
      result_next.status       = frame_status;
      result_next.reply_fields = is_short ? 8'd0 : header_store[srpc_pkg::HDR_FIELDS];
      byte_count_next          = '0;
      running_sum_next         = '0;
    end else if (is_short) begin
      running_sum_next = sum_folded;
      byte_count_next  = byte_count + 1'b1;
    end else if (payload_pos < {1'b0, reply_capacity}) begin
      emit                      = 1'b1;
      result_next.is_payload    = 1'b1;
      result_next.payload_byte  = head_token.data;
      result_next.payload_index = payload_pos[15:0];
      running_sum_next          = sum_folded;
      byte_count_next           = byte_count + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !head_token.is_close && is_short) begin
      header_store[hdr_slot] <= head_token.data;
    end
    if (pop && emit) begin
      result <= result_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (pop) begin
        byte_count  <= byte_count_next;
        running_sum <= running_sum_next;
        if (emit) begin
          out_valid <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== test/srpc_checker.sv =====
module srpc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        is_payload,
  input  logic [7:0]  payload_byte,
  input  logic [15:0] payload_index,
  input  logic        is_final,
  input  logic [2:0]  status,
  input  logic [7:0]  reply_fields,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fails,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [7:0]  want_dev = '0;
  logic [15:0] cap = '0;
  logic        framing = 1'b0;
  logic        esc_pend = 1'b0;
  logic [16:0] nbytes = '0;
  logic [8:0]  csum = '0;
  logic [7:0]  hdr [srpc_pkg::HDR_BYTES];
  srpc_pkg::result_t replies_due [$];
  srpc_pkg::result_t want;
  int          miss_cnt = 0;

  // end-around-carry byte add
  function automatic logic [8:0] fold_sum(input logic [8:0] s, input logic [7:0] b);
    logic [9:0] t;
    t = {1'b0, s} + {2'b00, b};
    return 9'(t[9:8]) + 9'(t[7:0]);
  endfunction

  function automatic logic [2:0] frame_verdict();
    logic [15:0] len;
    len = {hdr[srpc_pkg::HDR_LEN_HI], hdr[srpc_pkg::HDR_LEN_LO]};
    if (nbytes < srpc_pkg::HDR_BYTES) return srpc_pkg::ST_SHORT;
    if (nbytes != {1'b0, len}) return srpc_pkg::ST_LENGTH;
    if (hdr[srpc_pkg::HDR_SUM] != csum[7:0]) return srpc_pkg::ST_SUM;
    if (hdr[srpc_pkg::HDR_DEVICE] != want_dev) return srpc_pkg::ST_DEVICE;
    if (hdr[srpc_pkg::HDR_COMMAND] != srpc_pkg::CMD_ACK) return srpc_pkg::ST_NOACK;
    return srpc_pkg::ST_OK;
  endfunction

  // Advance the unframing state by one raw byte; returns 1 when a result is due.
  function automatic bit decode_byte(input logic [7:0] raw, output srpc_pkg::result_t r);
    logic [7:0] d;
    r = '0;
    if (!framing) begin
      if (raw == srpc_pkg::CODE_END) begin
        framing = 1'b1;
        esc_pend = 1'b0;
        nbytes = '0;
        csum = '0;
      end
      return 1'b0;
    end
    if (raw == srpc_pkg::CODE_END) begin
      esc_pend = 1'b0;
      if (nbytes == 0) return 1'b0;
      r.is_final = 1'b1;
      r.status = frame_verdict();
      r.reply_fields = (nbytes >= srpc_pkg::HDR_BYTES) ? hdr[srpc_pkg::HDR_FIELDS] : 8'h00;
      framing = 1'b0;
      nbytes = '0;
      csum = '0;
      return 1'b1;
    end
    if (esc_pend) begin
      esc_pend = 1'b0;
      d = (raw == srpc_pkg::CODE_ESC_END) ? srpc_pkg::CODE_END :
          (raw == srpc_pkg::CODE_ESC_ESC) ? srpc_pkg::CODE_ESC : raw;
    end else if (raw == srpc_pkg::CODE_ESC) begin
      esc_pend = 1'b1;
      return 1'b0;
    end else begin
      d = raw;
    end
    if (nbytes < srpc_pkg::HDR_BYTES) begin
      hdr[nbytes[2:0]] = d;
      csum = fold_sum(csum, (nbytes == srpc_pkg::HDR_SUM) ? 8'h00 : d);
      nbytes++;
      return 1'b0;
    end
    // drop payload past the buffer
    if (nbytes - srpc_pkg::HDR_BYTES >= cap) return 1'b0;
    r.is_payload = 1'b1;
    r.payload_byte = d;
    r.payload_index = 16'(nbytes - srpc_pkg::HDR_BYTES);
    csum = fold_sum(csum, d);
    nbytes++;
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      want_dev = '0;
      cap = '0;
      framing = 1'b0;
      esc_pend = 1'b0;
      nbytes = '0;
      csum = '0;
      replies_due.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr == {srpc_pkg::REG_EXPECTED_DEVICE, 2'b00}) want_dev = pwdata[7:0];
        else if (paddr == {srpc_pkg::REG_REPLY_CAPACITY, 2'b00}) cap = pwdata[15:0];
      end
      if (in_valid && !in_stall) begin
        if (decode_byte(rx_byte, want)) replies_due.push_back(want);
      end
      if (out_valid && !out_stall) begin
        if (replies_due.size() == 0) begin
          miss_cnt++;
          if (miss_cnt <= 10)
            $display("%0t: result with none due: pay=%0b byte=%02h idx=%0d fin=%0b stat=%0d",
                     $time, is_payload, payload_byte, payload_index, is_final, status);
        end else begin
          want = replies_due.pop_front();
          if (want.is_payload !== is_payload || want.payload_byte !== payload_byte ||
              want.payload_index !== payload_index || want.is_final !== is_final ||
              want.status !== status || want.reply_fields !== reply_fields) begin
            miss_cnt++;
            if (miss_cnt <= 10) begin
              $write("%0t: mismatch want pay=%0b byte=%02h idx=%0d fin=%0b stat=%0d ",
                     $time, want.is_payload, want.payload_byte, want.payload_index,
                     want.is_final, want.status);
              $display("fields=%02h got pay=%0b byte=%02h idx=%0d fin=%0b stat=%0d fields=%02h",
                       want.reply_fields, is_payload, payload_byte, payload_index,
                       is_final, status, reply_fields);
            end
          end
        end
      end
    end
    pending <= replies_due.size();
    fails <= miss_cnt;
  end

endmodule

// ===== test/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEMS  = 1250;    // raw bytes to send before stopping
  localparam int SETTLE = 16;      // cycles for framing bytes still queued in the block
  localparam int LIMIT  = 400000;  // cycle budget for the whole run

  // shapes of reply frame the generator can build
  typedef enum int {
    FR_GOOD, FR_SHORT, FR_LENGTH, FR_SUM, FR_DEVICE, FR_COMMAND, FR_GARBAGE
  } frame_kind_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic [7:0]  rx_byte = '0;
  logic        out_stall = 1'b0;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;

  logic        in_stall;
  logic        out_valid;
  logic        is_payload;
  logic [7:0]  payload_byte;
  logic [15:0] payload_index;
  logic        is_final;
  logic [2:0]  status;
  logic [7:0]  reply_fields;
  logic [31:0] prdata;
  logic        pready;

  int fails;
  int pending;

  // current register contents, mirrored so frames can be built to pass or fail
  logic [7:0]  cur_dev = '0;
  logic [15:0] cur_cap = '0;

  bit send_gaps = 1'b1;   // sender idles between transfers
  bit recv_gaps = 1'b1;   // receiver stalls between transfers
  int sent = 0;
  int cycles = 0;
  int stall_left = 0;
  int hold_w;

  always #4 clk = ~clk;

  slip_reply_packet_checker_top u_top (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_payload   (is_payload),
    .payload_byte (payload_byte),
    .payload_index(payload_index),
    .is_final     (is_final),
    .status       (status),
    .reply_fields (reply_fields),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  srpc_checker u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .is_payload   (is_payload),
    .payload_byte (payload_byte),
    .payload_index(payload_index),
    .is_final     (is_final),
    .status       (status),
    .reply_fields (reply_fields),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .fails        (fails),
    .pending      (pending)
  );

  // Receiver: after each result transfer, draw a random stall length and hold
  // stall high for that long. With recv_gaps off, take every result at once.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      hold_w = recv_gaps ? $urandom_range(0, 7) : 0;
      stall_left <= hold_w;
      out_stall <= (hold_w != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= (stall_left > 1);
    end
  end

  // Watchdog: drop the run if it runs far past any correct finish.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Send one raw byte: idle for a drawn gap, then hold the byte until the transfer.
  // Returns at the edge that took it, so the next byte can follow back to back.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = send_gaps ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  // Drain: stop sending, wait until every predicted result has come out, then give
  // bytes that make no result time to leave the block's queue.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; finish on an idle edge so the next
  // write never raises psel in the step where this one lowers it.
  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [7:0] dev, input logic [15:0] cap);
    write_reg(srpc_pkg::REG_EXPECTED_DEVICE, {24'h0, dev});
    write_reg(srpc_pkg::REG_REPLY_CAPACITY, {16'h0, cap});
    cur_dev = dev;
    cur_cap = cap;
  endtask

  // end-around-carry byte add, used only to build frames with a valid checksum
  function automatic logic [8:0] add_carry(input logic [8:0] s, input logic [7:0] b);
    logic [9:0] t;
    t = {1'b0, s} + {2'b00, b};
    return 9'(t[9:8]) + 9'(t[7:0]);
  endfunction

  // Build one reply frame of the given shape against the current registers, SLIP
  // encode it and send it, with some noise, doubled ENDs and stray escapes.
  task automatic send_frame(input frame_kind_e kind);
    logic [7:0]  body [$];
    logic [7:0]  pay [$];
    logic [7:0]  dev;
    logic [7:0]  cmd;
    logic [7:0]  fld;
    logic [7:0]  sum;
    logic [7:0]  b;
    logic [15:0] len;
    logic [8:0]  s;
    int          n;
    int          acc;

    // mostly short payloads, now and then a longer one that may overrun capacity
    n = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 8);
    acc = (n < cur_cap) ? n : cur_cap;
    dev = cur_dev;
    cmd = srpc_pkg::CMD_ACK;
    fld = 8'($urandom);
    len = 16'(srpc_pkg::HDR_BYTES + acc);
    if (kind == FR_DEVICE) dev = cur_dev ^ 8'($urandom_range(1, 255));
    if (kind == FR_COMMAND) cmd = srpc_pkg::CMD_ACK ^ 8'($urandom_range(1, 255));
    if (kind == FR_LENGTH) len = len ^ 16'(1 << $urandom_range(0, 15));
    if (kind == FR_GARBAGE) begin
      dev = 8'($urandom);
      cmd = 8'($urandom);
      len = 16'($urandom);
    end

    // checksum byte itself counts as zero
    s = '0;
    s = add_carry(s, dev);
    s = add_carry(s, cmd);
    s = add_carry(s, len[7:0]);
    s = add_carry(s, len[15:8]);
    s = add_carry(s, fld);
    for (int i = 0; i < n; i++) begin
      // lean on the framing codes so escapes show up often
      case ($urandom_range(0, 5))
        0: begin
          b = srpc_pkg::CODE_END;
        end
        1: begin
          b = srpc_pkg::CODE_ESC;
        end
        2: begin
          b = $urandom_range(0, 1) ? srpc_pkg::CODE_ESC_END : srpc_pkg::CODE_ESC_ESC;
        end
        default: begin
          b = 8'($urandom);
        end
      endcase
      pay.push_back(b);
      if (i < acc) s = add_carry(s, b);
    end
    sum = s[7:0];
    if (kind == FR_SUM) sum = sum ^ 8'($urandom_range(1, 255));
    if (kind == FR_GARBAGE) sum = 8'($urandom);

    body = {dev, cmd, len[7:0], len[15:8], sum, fld};
    body = {body, pay};
    if (kind == FR_SHORT) begin
      body.delete();
      repeat ($urandom_range(1, 5)) body.push_back(8'($urandom));
    end

    // line noise before the opening END; never an END itself
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        b = 8'($urandom_range(0, 254));
        send_byte((b >= srpc_pkg::CODE_END) ? b + 8'd1 : b);
      end
    end
    send_byte(srpc_pkg::CODE_END);
    if ($urandom_range(0, 5) == 0) send_byte(srpc_pkg::CODE_END);
    foreach (body[j]) begin
      if (body[j] == srpc_pkg::CODE_END) begin
        send_byte(srpc_pkg::CODE_ESC);
        send_byte(srpc_pkg::CODE_ESC_END);
      end else if (body[j] == srpc_pkg::CODE_ESC) begin
        // an escaped ESC also decodes to itself as an unknown escape
        send_byte(srpc_pkg::CODE_ESC);
        send_byte(($urandom_range(0, 3) == 0) ? srpc_pkg::CODE_ESC : srpc_pkg::CODE_ESC_ESC);
      end else if (body[j] != srpc_pkg::CODE_ESC_END && body[j] != srpc_pkg::CODE_ESC_ESC &&
                   $urandom_range(0, 9) == 0) begin
        // unknown escape: passes the byte through unchanged
        send_byte(srpc_pkg::CODE_ESC);
        send_byte(body[j]);
      end else begin
        send_byte(body[j]);
      end
    end
    // now and then leave an escape hanging before the closing END
    if ($urandom_range(0, 7) == 0) send_byte(srpc_pkg::CODE_ESC);
    send_byte(srpc_pkg::CODE_END);
  endtask

  initial begin : stimulus
    int          phase;
    int          r;
    logic [7:0]  dev;
    logic [15:0] cap;

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed, with the registers at their reset values.
    send_byte(8'h00);                   // outside a frame: ignored
    send_byte(8'hFF);
    send_byte(srpc_pkg::CODE_END);      // open
    send_byte(srpc_pkg::CODE_END);      // doubled END: empty, stays open
    send_byte(8'h12);
    send_byte(srpc_pkg::CODE_END);      // one byte: short
    send_byte(srpc_pkg::CODE_END);
    send_byte(srpc_pkg::CODE_ESC);
    send_byte(srpc_pkg::CODE_END);      // END after ESC with nothing decoded: stays open
    send_byte(srpc_pkg::CODE_ESC);
    send_byte(8'h41);                   // unknown escape yields the byte
    send_byte(srpc_pkg::CODE_END);      // short again
    send_frame(FR_GOOD);

    // Random phases; each starts idle with a fresh register setting, the first two
    // at the extremes.
    phase = 0;
    while (sent < ITEMS) begin
      settle();
      case (phase)
        0: begin
          dev = 8'hFF;
          cap = 16'd65529;
        end
        1: begin
          dev = 8'h00;
          cap = 16'd0;
        end
        default: begin
          case ($urandom_range(0, 3))
            0: begin
              dev = srpc_pkg::CMD_ACK;
            end
            1: begin
              dev = srpc_pkg::CODE_END;
            end
            default: begin
              dev = 8'($urandom);
            end
          endcase
          cap = ($urandom_range(0, 7) == 0) ? 16'd65529 : 16'($urandom_range(0, 24));
        end
      endcase
      set_config(dev, cap);
      send_gaps = ($urandom_range(0, 3) != 0);
      recv_gaps = ($urandom_range(0, 3) != 0);
      repeat (12) begin
        // hold off now and then until the output side has caught up
        if ($urandom_range(0, 15) == 0) settle();
        if ($urandom_range(0, 4) == 0) begin
          send_gaps = ($urandom_range(0, 3) != 0);
          recv_gaps = ($urandom_range(0, 3) != 0);
        end
        r = $urandom_range(0, 19);
        send_frame((r >= 11 && r <= 16) ? frame_kind_e'(r - 10) : FR_GOOD);
      end
      phase++;
    end

    settle();
    if (fails == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
